// File: rtl/matrix_orthogonality_check_top_macros.svh
// Assertion macros shared by the matrix orthogonality check.
`ifndef MATRIX_ORTHOGONALITY_CHECK_TOP_MACROS_SVH
`define MATRIX_ORTHOGONALITY_CHECK_TOP_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define MOC_ASSERT_SAME(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define MOC_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/moc_pkg.sv
// Package: constants, types and codes of the matrix orthogonality check.
package moc_pkg;

  localparam int DIM          = 3;
  localparam int ELEM_WIDTH   = 16;
  localparam int CELLS        = DIM * DIM;
  localparam int IDX_W        = $clog2(CELLS);
  localparam int DIM_W        = $clog2(DIM);
  localparam int PROD_W       = 2 * ELEM_WIDTH;
  localparam int ACC_W        = PROD_W + $clog2(DIM);
  localparam int S_TDATA_W    = ((ELEM_WIDTH + 7) / 8) * 8;
  localparam int VERDICT_W    = 2;
  localparam int M_TDATA_W    = 8;
  localparam int DRAIN_CYCLES = 3;
  localparam int DRAIN_W      = $clog2(DRAIN_CYCLES + 1);

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_OK      = 2'd0,
    VERDICT_DIAG    = 2'd1,
    VERDICT_OFFDIAG = 2'd2
  } moc_verdict_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_RUN,
    ST_DRAIN
  } moc_state_t;

  // One multiply-accumulate step issued by the sequencer.
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             diag;
    logic             clear;
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
  } moc_step_t;

  // Element store write from the load side.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
  } moc_load_t;

endpackage

// File: rtl/moc_store.sv
// Element store: one write port, two registered read ports.
module moc_store (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [moc_pkg::IDX_W-1:0]             waddr,
  input  logic signed [moc_pkg::ELEM_WIDTH-1:0] wdata,
  input  logic [moc_pkg::IDX_W-1:0]             raddr_a,
  input  logic [moc_pkg::IDX_W-1:0]             raddr_b,
  output logic signed [moc_pkg::ELEM_WIDTH-1:0] rdata_a,
  output logic signed [moc_pkg::ELEM_WIDTH-1:0] rdata_b
);
  import moc_pkg::*;

  logic signed [ELEM_WIDTH-1:0] mem [CELLS];

  // Write the loaded element
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read both operands
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: rtl/moc_mac.sv
// Shared multiply-accumulate unit and first-failure compare.
module moc_mac (
  input  logic                                  clk,
  input  logic                                  rst,
  input  moc_pkg::moc_step_t                    step,
  input  logic signed [moc_pkg::ELEM_WIDTH-1:0] rdata_a,
  input  logic signed [moc_pkg::ELEM_WIDTH-1:0] rdata_b,
  output moc_pkg::moc_verdict_t                 verdict
);
  import moc_pkg::*;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic diag;
  } moc_tok_t;

  localparam logic [ACC_W-1:0] ACC_ONE = ACC_W'(1);

  moc_tok_t                  tok1;
  moc_tok_t                  tok2;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   acc;
  logic                      done;
  logic                      done_diag;
  logic                      failed;
  logic                      mismatch;

  // Advance step tokens alongside the read and multiply stages
  always_ff @(posedge clk) begin
    if (rst) begin
      tok1.valid <= 1'b0;
      tok2.valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      tok1.valid <= step.valid;
      tok2.valid <= tok1.valid;
      done       <= tok2.valid && tok2.last;
    end
    tok1.first <= step.first;
    tok1.last  <= step.last;
    tok1.diag  <= step.diag;
    tok2.first <= tok1.first;
    tok2.last  <= tok1.last;
    tok2.diag  <= tok1.diag;
    done_diag  <= tok2.diag;
  end

  // Multiply the two operands
  always_ff @(posedge clk) begin
    prod <= rdata_a * rdata_b;
  end

  assign prod_ext = ACC_W'(prod);

  // Accumulate the dot product, restart on the first term
  always_ff @(posedge clk) begin
    if (tok2.valid) begin
      if (tok2.first) begin
        acc <= prod_ext;
      end else begin
        acc <= acc + prod_ext;
      end
    end
  end

  // Compare a finished entry against the identity
  assign mismatch = done_diag ? (acc != ACC_ONE) : (acc != '0);

  // Hold the first failure of the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      failed  <= 1'b0;
      verdict <= VERDICT_OK;
    end else if (step.clear) begin
      failed  <= 1'b0;
      verdict <= VERDICT_OK;
    end else if (done && !failed && mismatch) begin
      failed  <= 1'b1;
      verdict <= done_diag ? VERDICT_DIAG : VERDICT_OFFDIAG;
    end
  end

endmodule

// File: rtl/moc_ctrl.sv
// Sequencer: load counting, step issue, drain and verdict output register.
module moc_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  input  moc_pkg::moc_verdict_t          verdict_in,
  output moc_pkg::moc_verdict_t          verdict_out,
  output moc_pkg::moc_load_t             load,
  output moc_pkg::moc_step_t             step
);
  import moc_pkg::*;

  localparam logic [IDX_W-1:0]   LAST_CELL = IDX_W'(CELLS - 1);
  localparam logic [DIM_W-1:0]   LAST_DIM  = DIM_W'(DIM - 1);
  localparam logic [DRAIN_W-1:0] DRAIN_END = DRAIN_W'(DRAIN_CYCLES);

  moc_state_t         state;
  moc_state_t         state_next;
  logic [IDX_W-1:0]   load_count;
  logic [DIM_W-1:0]   row;
  logic [DIM_W-1:0]   col;
  logic [DIM_W-1:0]   term;
  logic [DRAIN_W-1:0] drain_count;
  logic               load_last;
  logic               run_last;
  logic               capture;

  assign load_last = (load_count == LAST_CELL);
  assign run_last  = (row == LAST_DIM) && (col == LAST_DIM) && (term == LAST_DIM);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (load.we && load_last) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (run_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (capture) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_tready   = 1'b0;
    step.valid = 1'b0;
    capture    = 1'b0;
    case (state)
      ST_LOAD: begin
        s_tready = 1'b1;
      end
      ST_RUN: begin
        step.valid = 1'b1;
      end
      ST_DRAIN: begin
        capture = (drain_count == DRAIN_END) && (!m_tvalid || m_tready);
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
    load.we    = s_tvalid && s_tready;
    load.addr  = load_count;
    step.clear = load.we && load_last;
    step.first = (term == '0);
    step.last  = (term == LAST_DIM);
    step.diag  = (row == col);
    step.idx_a = IDX_W'(row) * IDX_W'(DIM) + IDX_W'(term);
    step.idx_b = IDX_W'(col) * IDX_W'(DIM) + IDX_W'(term);
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Count loaded elements
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (load.we) begin
      load_count <= load_last ? '0 : load_count + 1'b1;
    end
  end

  // Advance term, column and row of the product scan
  always_ff @(posedge clk) begin
    if (rst) begin
      row  <= '0;
      col  <= '0;
      term <= '0;
    end else if (step.valid) begin
      if (term == LAST_DIM) begin
        term <= '0;
        if (col == LAST_DIM) begin
          col <= '0;
          row <= (row == LAST_DIM) ? '0 : row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end else begin
        term <= term + 1'b1;
      end
    end
  end

  // Count pipeline drain cycles
  always_ff @(posedge clk) begin
    if (rst) begin
      drain_count <= '0;
    end else if (state != ST_DRAIN) begin
      drain_count <= '0;
    end else if (drain_count != DRAIN_END) begin
      drain_count <= drain_count + 1'b1;
    end
  end

  // Hold the verdict until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (capture) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      verdict_out <= verdict_in;
    end
  end

endmodule

// File: rtl/matrix_orthogonality_check_top.sv
// Top level of the matrix orthogonality check.
// The block takes a 3x3 matrix of signed 16-bit elements, row-major, one element
// per item at up to one per cycle, then runs the 27 multiply-accumulate steps of
// A * transpose(A) on one shared multiplier, one step per cycle, followed by a
// pipeline drain (store read, multiply, accumulate, compare). s_tready is low while
// the product runs and drains. The verdict (0 identity, 1 first failure on the
// diagonal, 2 first failure off the diagonal) waits in an output register, so the
// next matrix may load while it is pending; a second verdict waits in drain until
// the first is taken.
module matrix_orthogonality_check_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [moc_pkg::S_TDATA_W-1:0]   s_tdata,  // [15:0] element
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [moc_pkg::M_TDATA_W-1:0]   m_tdata   // [1:0] verdict, rest zero
);
  import moc_pkg::*;

  `include "matrix_orthogonality_check_top_macros.svh"

  moc_load_t                    load;
  moc_step_t                    step;
  moc_verdict_t                 verdict_mac;
  moc_verdict_t                 verdict_out;
  logic signed [ELEM_WIDTH-1:0] rdata_a;
  logic signed [ELEM_WIDTH-1:0] rdata_b;

  moc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .verdict_in  (verdict_mac),
    .verdict_out (verdict_out),
    .load        (load),
    .step        (step)
  );

  moc_store u_store (
    .clk     (clk),
    .we      (load.we),
    .waddr   (load.addr),
    .wdata   (signed'(s_tdata[ELEM_WIDTH-1:0])),
    .raddr_a (step.idx_a),
    .raddr_b (step.idx_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  moc_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b),
    .verdict (verdict_mac)
  );

  // Pad the verdict to a whole byte
  assign m_tdata = {(M_TDATA_W - VERDICT_W)'(0), verdict_out};

  // No element is taken while the product runs
  `MOC_ASSERT_SAME(a_no_load_in_run, clk, rst, step.valid, !s_tready, "element accepted during run")
  // The scan starts right after the last element of a matrix
  `MOC_ASSERT_NEXT(a_run_after_load, clk, rst, step.clear, step.valid, "scan did not start")
  // Store writes stay inside the matrix
  `MOC_ASSERT_SAME(a_write_in_range, clk, rst, load.we, load.addr <= IDX_W'(CELLS - 1), "bad write")

endmodule

// File: bench/moc_orthogonality_checker.sv
// Checker for the matrix orthogonality check: predicts verdicts and compares them.
`timescale 1ns / 1ps

module moc_orthogonality_checker
  import moc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // [15:0] element
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,  // [1:0] verdict, rest zero
  output int                   mismatches,
  output int                   verdicts_owed
);

  // Shadow copy of the matrix being loaded, row-major.
  logic signed [ELEM_WIDTH-1:0] shadow_cells [CELLS];
  int                           fill_pos = 0;
  moc_verdict_t                 verdict_queue [$];
  int                           error_tally = 0;

  assign mismatches = error_tally;

  // Scan A * transpose(A) row-major and report the first entry that breaks identity.
  function automatic moc_verdict_t orthogonality_verdict();
    longint dot;
    int     r;
    int     c;
    int     k;
    for (r = 0; r < DIM; r++) begin
      for (c = 0; c < DIM; c++) begin
        dot = 0;
        for (k = 0; k < DIM; k++) begin
          dot += longint'(shadow_cells[r*DIM+k]) * longint'(shadow_cells[c*DIM+k]);
        end
        if (r == c) begin
          if (dot != 1) return VERDICT_DIAG;
        end else if (dot != 0) begin
          return VERDICT_OFFDIAG;
        end
      end
    end
    return VERDICT_OK;
  endfunction

  // Watch both channels at the clock edge; compare first, then record new elements.
  always @(posedge clk) begin : watch
    moc_verdict_t         expected;
    logic [M_TDATA_W-1:0] expected_tdata;
    if (rst) begin
      fill_pos = 0;
      verdict_queue.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (verdict_queue.size() == 0) begin
          error_tally++;
          $display("%0t: verdict item with none pending, expected none, got tdata 0x%02h",
                   $time, m_tdata);
        end else begin
          expected       = verdict_queue.pop_front();
          expected_tdata = '0;
          expected_tdata[VERDICT_W-1:0] = expected;
          if (m_tdata !== expected_tdata) begin
            error_tally++;
            $display("%0t: verdict mismatch, expected tdata 0x%02h, got tdata 0x%02h",
                     $time, expected_tdata, m_tdata);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        shadow_cells[fill_pos] = s_tdata[ELEM_WIDTH-1:0];
        if (fill_pos == CELLS - 1) begin
          verdict_queue.push_back(orthogonality_verdict());
          fill_pos = 0;
        end else begin
          fill_pos++;
        end
      end
    end
    verdicts_owed <= verdict_queue.size();
  end

endmodule

// File: bench/tb_matrix_orthogonality_check_top.sv
// Testbench top for the matrix orthogonality check: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_matrix_orthogonality_check_top;
  import moc_pkg::*;

  localparam int RANDOM_MATRICES = 72;
  localparam int HOLD_AT         = 25;
  localparam int HOLD_CYCLES     = 400;
  localparam int QUIET_LIMIT     = 4000;
  localparam int TAIL_CYCLES     = 60;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;  // [15:0] element
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;        // [1:0] verdict, rest zero

  int mismatches;
  int verdicts_owed;
  int quiet_cycles = 0;
  bit sender_no_gaps = 1'b0;

  logic signed [ELEM_WIDTH-1:0] mat [CELLS];

  matrix_orthogonality_check_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  moc_orthogonality_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .mismatches    (mismatches),
    .verdicts_owed (verdicts_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort when neither channel moves an item for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one element after a random gap and hold it until accepted.
  task automatic send_element(input logic [ELEM_WIDTH-1:0] value);
    int gap;
    gap = sender_no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_matrix();
    int i;
    for (i = 0; i < CELLS; i++) send_element(mat[i]);
  endtask

  task automatic set_rows(input int r0 [DIM], input int r1 [DIM], input int r2 [DIM]);
    int k;
    for (k = 0; k < DIM; k++) begin
      mat[k]         = ELEM_WIDTH'(r0[k]);
      mat[DIM+k]     = ELEM_WIDTH'(r1[k]);
      mat[2*DIM+k]   = ELEM_WIDTH'(r2[k]);
    end
  endtask

  // Random permutation matrix with random signs: always orthogonal.
  task automatic build_signed_permutation();
    int perm [DIM];
    int i;
    int j;
    int t;
    for (i = 0; i < DIM; i++) perm[i] = i;
    for (i = DIM - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      t       = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (i = 0; i < CELLS; i++) mat[i] = '0;
    for (i = 0; i < DIM; i++) mat[i*DIM+perm[i]] = ELEM_WIDTH'($urandom_range(0, 1) ? 1 : -1);
  endtask

  // Receiver: random stalls, one stretch without stalls and one long hold-off.
  initial begin : sink
    int stall;
    int taken;
    bit held;
    taken = 0;
    held  = 1'b0;
    wait (!rst);
    forever begin
      if (taken >= 40 && taken < 55) stall = 0;
      else stall = $urandom_range(0, 10);
      if (taken == HOLD_AT && !held) begin
        stall = HOLD_CYCLES;
        held  = 1'b1;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
    end
  end

  initial begin : stimulus
    int n;
    int i;
    int kind;
    int spot;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Signed permutation: product is the identity.
    set_rows('{0, -1, 0}, '{1, 0, 0}, '{0, 0, -1});
    send_matrix();
    // Extreme elements: wide diagonal sums far from one.
    set_rows('{-32768, -32768, -32768}, '{32767, 32767, 32767}, '{-32768, 32767, 0});
    send_matrix();
    // Off-diagonal entry fails before a later diagonal one.
    set_rows('{1, 0, 0}, '{1, 1, 0}, '{0, 32767, -32768});
    send_matrix();

    for (n = 0; n < RANDOM_MATRICES; n++) begin
      sender_no_gaps = (n >= 20 && n < 28);
      // Let every verdict drain before going on.
      if (n == 40) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (verdicts_owed != 0) @(posedge clk);
      end
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: begin
          build_signed_permutation();
        end
        4, 5: begin
          build_signed_permutation();
          spot = $urandom_range(0, CELLS - 1);
          if ($urandom_range(0, 1)) mat[spot] = ELEM_WIDTH'($urandom_range(0, 4) - 2);
          else mat[spot] = ELEM_WIDTH'($urandom_range(0, 16'hFFFF));
        end
        6: begin
          for (i = 0; i < CELLS; i++) mat[i] = ELEM_WIDTH'($urandom_range(0, 16'hFFFF));
        end
        7: begin
          for (i = 0; i < CELLS; i++) mat[i] = ELEM_WIDTH'($urandom_range(0, 2) - 1);
        end
        default: begin
          for (i = 0; i < CELLS; i++) begin
            case ($urandom_range(0, 4))
              0:       mat[i] = ELEM_WIDTH'(-32768);
              1:       mat[i] = ELEM_WIDTH'(32767);
              2:       mat[i] = ELEM_WIDTH'(1);
              3:       mat[i] = ELEM_WIDTH'(-1);
              default: mat[i] = '0;
            endcase
          end
        end
      endcase
      send_matrix();
    end
    sender_no_gaps = 1'b0;
    s_tvalid <= 1'b0;

    // Drain, then watch a while longer for stray verdicts.
    @(posedge clk);
    while (verdicts_owed != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && verdicts_owed == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
